// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, ignored while in reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/gss_pkg.sv =====
package gss_pkg;

  localparam int COORD_W     = 32;
  localparam int VAL_W       = 32;
  localparam int TOL_W       = 31;
  localparam int ITER_W      = 16;
  localparam int PROBE_W     = 17;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int RATIO_SHIFT = 16;
  localparam int PROD_W      = COORD_W + RATIO_SHIFT;

  // 0.618... as a 16-bit fraction
  localparam logic [RATIO_SHIFT-1:0] RATIO_NUM = 16'd40504;

  localparam logic OP_START = 1'b0;
  localparam logic OP_VALUE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PROBE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ERR   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd3;

  localparam logic [COORD_W-1:0] LEFT_RST  = 32'd0;
  localparam logic [COORD_W-1:0] RIGHT_RST = 32'd65536;
  localparam logic [TOL_W-1:0]   TOL_RST   = 31'd66;
  localparam logic [ITER_W-1:0]  LIMIT_RST = 16'd1000;

  typedef struct packed {
    logic                      op;
    logic signed [VAL_W-1:0]   value;
  } gss_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [COORD_W-1:0] point;
    logic [COORD_W-1:0]        accuracy;
    logic [ITER_W-1:0]         iterations;
    logic [PROBE_W-1:0]        probes;
  } gss_out_t;

  typedef struct packed {
    logic [COORD_W-1:0] left_bound;
    logic [COORD_W-1:0] right_bound;
    logic [TOL_W-1:0]   tolerance;
    logic [ITER_W-1:0]  iteration_limit;
  } gss_cfg_t;

  // interval runs backwards when b is below a
  function automatic logic gss_rev(input logic [COORD_W-1:0] a, input logic [COORD_W-1:0] b);
    return $signed(b) < $signed(a);
  endfunction

  function automatic logic [COORD_W-1:0] gss_width(input logic [COORD_W-1:0] a,
                                                    input logic [COORD_W-1:0] b);
    return gss_rev(a, b) ? (a - b) : (b - a);
  endfunction

  // floor (or ceil when up) of m * RATIO_NUM / 2^RATIO_SHIFT
  function automatic logic [COORD_W-1:0] gss_ratio(input logic [COORD_W-1:0] m, input logic up);
    logic [PROD_W-1:0] prod;
    logic              frac_nz;
    prod    = {{RATIO_SHIFT{1'b0}}, m} * {{COORD_W{1'b0}}, RATIO_NUM};
    frac_nz = prod[RATIO_SHIFT-1:0] != '0;
    return prod[PROD_W-1:RATIO_SHIFT] + {{(COORD_W-1){1'b0}}, up & frac_nz};
  endfunction

  function automatic logic [COORD_W-1:0] gss_step(input logic [COORD_W-1:0] base,
                                                   input logic [COORD_W-1:0] delta,
                                                   input logic add);
    return add ? (base + delta) : (base - delta);
  endfunction

endpackage

// ===== rtl/gss_cfg_regs.sv =====
module gss_cfg_regs import gss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [COORD_W-1:0]   wr_data,
  output gss_cfg_t             cfg
);

  gss_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_bound      <= LEFT_RST;
      cfg_r.right_bound     <= RIGHT_RST;
      cfg_r.tolerance       <= TOL_RST;
      cfg_r.iteration_limit <= LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_LEFT:  cfg_r.left_bound      <= wr_data;
        CFG_RIGHT: cfg_r.right_bound     <= wr_data;
        CFG_TOL:   cfg_r.tolerance       <= wr_data[TOL_W-1:0];
        CFG_LIMIT: cfg_r.iteration_limit <= wr_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/gss_engine.sv =====
module gss_engine import gss_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     step,
  input  gss_in_t  item,
  input  gss_cfg_t cfg,
  output gss_out_t result
);

  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_SECOND, PH_NEW} phase_t;

  phase_t              phase_r, phase_nxt;
  logic                pending_r, pending_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [COORD_W-1:0]  left_r, left_nxt, right_r, right_nxt;
  logic [COORD_W-1:0]  plo_r, plo_nxt, phi_r, phi_nxt;
  logic [VAL_W-1:0]    vlo_r, vlo_nxt, vhi_r, vhi_nxt;

  logic                start, go_left, nrev, st_rev, cur_rev, mul_up, stop;
  logic [COORD_W-1:0]  cur_w, nw, st_w, mul_w, rat, nl, nr;
  logic [COORD_W-1:0]  st_plo, st_phi, nar_pt, mid, half_up;
  logic [VAL_W-1:0]    v_lo_eff, v_hi_eff;
  logic [ITER_W-1:0]   iter_inc;

  assign start   = item.op == OP_START;
  assign cur_w   = gss_width(left_r, right_r);
  assign cur_rev = gss_rev(left_r, right_r);

  // the incoming value replaces whichever side is pending
  assign v_lo_eff = (phase_r == PH_NEW && !pending_r) ? item.value : vlo_r;
  assign v_hi_eff = (phase_r == PH_SECOND || (phase_r == PH_NEW && pending_r)) ?
                    item.value : vhi_r;
  assign go_left  = $signed(v_lo_eff) > $signed(v_hi_eff);

  assign nl   = go_left ? plo_r : left_r;
  assign nr   = go_left ? right_r : phi_r;
  assign nw   = gss_width(nl, nr);
  assign nrev = gss_rev(nl, nr);

  assign st_w   = gss_width(cfg.left_bound, cfg.right_bound);
  assign st_rev = gss_rev(cfg.left_bound, cfg.right_bound);

  // one ratio multiply serves both the start and the narrowing path
  assign mul_w  = start ? st_w : nw;
  assign mul_up = start ? st_rev : nrev;
  assign rat    = gss_ratio(mul_w, mul_up);

  assign st_plo = gss_step(cfg.right_bound, rat, st_rev);
  assign st_phi = gss_step(cfg.left_bound, rat, !st_rev);
  assign nar_pt = gss_step(go_left ? nl : nr, rat, go_left != nrev);

  assign half_up = {1'b0, cur_w[COORD_W-1:1]} + {{(COORD_W-1){1'b0}}, cur_w[0]};
  assign mid     = cur_rev ? (left_r - half_up) : (left_r + {1'b0, cur_w[COORD_W-1:1]});

  assign stop     = (iter_r == cfg.iteration_limit) || (cur_w < {cfg.tolerance, 1'b0});
  assign iter_inc = iter_r + ITER_W'(1);

  always_comb begin
    phase_nxt   = phase_r;
    pending_nxt = pending_r;
    iter_nxt    = iter_r;
    left_nxt    = left_r;
    right_nxt   = right_r;
    plo_nxt     = plo_r;
    phi_nxt     = phi_r;
    vlo_nxt     = vlo_r;
    vhi_nxt     = vhi_r;
    result      = '0;
    priority if (start) begin
      left_nxt          = cfg.left_bound;
      right_nxt         = cfg.right_bound;
      plo_nxt           = st_plo;
      phi_nxt           = st_phi;
      iter_nxt          = '0;
      pending_nxt       = 1'b0;
      phase_nxt         = PH_FIRST;
      result.status     = ST_PROBE;
      result.point      = st_plo;
      result.accuracy   = st_w;
      result.probes     = PROBE_W'(1);
    end else if (phase_r == PH_IDLE) begin
      result.status = ST_ERR;
    end else if (phase_r == PH_FIRST) begin
      vlo_nxt           = item.value;
      phase_nxt         = PH_SECOND;
      result.status     = ST_PROBE;
      result.point      = phi_r;
      result.accuracy   = cur_w;
      result.iterations = iter_r;
      result.probes     = PROBE_W'(2);
    end else if (stop) begin
      vlo_nxt           = v_lo_eff;
      vhi_nxt           = v_hi_eff;
      phase_nxt         = PH_IDLE;
      result.status     = ST_DONE;
      result.point      = mid;
      result.accuracy   = cur_w;
      result.iterations = iter_r;
      result.probes     = {1'b0, iter_r} + PROBE_W'(2);
    end else begin
      // keep the better interior probe, request one new point
      if (go_left) begin
        left_nxt = plo_r;
        plo_nxt  = phi_r;
        phi_nxt  = nar_pt;
        vlo_nxt  = v_hi_eff;
        vhi_nxt  = v_hi_eff;
      end else begin
        right_nxt = phi_r;
        phi_nxt   = plo_r;
        plo_nxt   = nar_pt;
        vlo_nxt   = v_lo_eff;
        vhi_nxt   = v_lo_eff;
      end
      pending_nxt       = go_left;
      iter_nxt          = iter_inc;
      phase_nxt         = PH_NEW;
      result.status     = ST_PROBE;
      result.point      = nar_pt;
      result.accuracy   = cur_w;
      result.iterations = iter_inc;
      result.probes     = {1'b0, iter_inc} + PROBE_W'(2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      pending_r <= 1'b0;
      iter_r    <= '0;
    end else if (step) begin
      phase_r   <= phase_nxt;
      pending_r <= pending_nxt;
      iter_r    <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      plo_r   <= plo_nxt;
      phi_r   <= phi_nxt;
      vlo_r   <= vlo_nxt;
      vhi_r   <= vhi_nxt;
    end
  end

endmodule

// ===== rtl/golden_section_minimum_search_core.sv =====
// Golden-section minimum search in Q16.16. The block emits probe points and takes
// back function values: one result per input transaction, in order. An accepted
// transaction lands in an input register, is processed by a single combinational
// step (interval width, one 32x16 multiply by the ratio constant, one add) that
// updates the search state when the output register is free or being emptied,
// and its result is held in that output register, which drives out_valid.
// One transaction per cycle is sustained while the output side keeps up; the
// per-cycle state recurrence through that multiply-add sets the clock.
// Configuration writes are always taken and must only be issued while no search
// transaction is outstanding.
module golden_section_minimum_search_core import gss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gss_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gss_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  gss_in_t  in_r;
  logic     in_vld_r;
  gss_out_t out_r;
  logic     out_vld_r;
  gss_out_t res;
  gss_cfg_t cfg;
  logic     adv;

  assign cfg_ready = 1'b1;
  assign adv       = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || adv;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  gss_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  gss_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .item   (in_r),
    .cfg    (cfg),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (adv) begin
      out_r <= res;
    end
  end

endmodule

// ===== rtl/gss_checker.sv =====
`include "assert_macros.svh"

module gss_checker import gss_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     out_valid,
  input logic     out_ready,
  input gss_out_t out_data
);

  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

  // an ignored transaction reports nothing else
  `ASSERT_IMPLY(a_err_zero, clk, rst_n, out_valid && out_data.status == ST_ERR, out_data.point == '0 && out_data.accuracy == '0 && out_data.iterations == '0 && out_data.probes == '0)

  `ASSERT_IMPLY(a_done_probes, clk, rst_n, out_valid && out_data.status == ST_DONE, out_data.probes == ({1'b0, out_data.iterations} + PROBE_W'(2)))

  // the first two probes come before any narrowing
  `ASSERT_IMPLY(a_probe_count, clk, rst_n, out_valid && out_data.status == ST_PROBE && out_data.iterations == '0, out_data.probes == PROBE_W'(1) || out_data.probes == PROBE_W'(2))

endmodule

bind golden_section_minimum_search_core gss_checker u_gss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
